// ===== design/tlpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_pkg: shared types, constants and tables of the traffic phase controller
// Phase numbering, light codes, dwell register indexes, reset values and the
// fixed next-phase table.
// ----------------------------------------------------------------------------
package tlpc_pkg;

   localparam int PHASE_W   = 3;
   localparam int NUM_PHASE = 8;
   localparam int COUNT_W   = 16;
   localparam int REQ_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [PHASE_W-1:0]    phase_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [REQ_W-1:0]      req_bits_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [1:0]            road_light_type;

   // phases, table order
   localparam phase_type PH_GREEN1    = 3'd0;
   localparam phase_type PH_YELLOW1   = 3'd1;
   localparam phase_type PH_ALL_RED1  = 3'd2;
   localparam phase_type PH_GREEN2    = 3'd3;
   localparam phase_type PH_YELLOW2   = 3'd4;
   localparam phase_type PH_ALL_RED2  = 3'd5;
   localparam phase_type PH_WALK      = 3'd6;
   localparam phase_type PH_WALK_CLR  = 3'd7;

   // road light codes
   localparam road_light_type LIGHT_RED    = 2'd0;
   localparam road_light_type LIGHT_YELLOW = 2'd1;
   localparam road_light_type LIGHT_GREEN  = 2'd2;

   // dwell register indexes
   localparam csr_index_type CSR_GREEN      = 3'd0;
   localparam csr_index_type CSR_YELLOW     = 3'd1;
   localparam csr_index_type CSR_ALL_RED    = 3'd2;
   localparam csr_index_type CSR_WALK       = 3'd3;
   localparam csr_index_type CSR_WALK_CLEAR = 3'd4;

   // dwell reset values
   localparam count_type RST_GREEN      = 16'd3000;
   localparam count_type RST_YELLOW     = 16'd500;
   localparam count_type RST_ALL_RED    = 16'd200;
   localparam count_type RST_WALK       = 16'd3000;
   localparam count_type RST_WALK_CLEAR = 16'd500;

   typedef struct packed {
      count_type green;
      count_type yellow;
      count_type all_red;
      count_type walk;
      count_type walk_clear;
   } dwell_set_type;

   typedef struct packed {
      road_light_type road1_light;
      road_light_type road2_light;
      logic           walk_light;
      phase_type      phase;
      logic           phase_changed;
   } step_result_type;

   // next phase, row = current phase, column = request index
   // (car_road1 | car_road2 << 1 | pedestrian << 2)
   localparam phase_type NEXT_TAB [NUM_PHASE][NUM_PHASE] = '{
      '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
      '{3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2},
      '{3'd3, 3'd3, 3'd3, 3'd3, 3'd6, 3'd6, 3'd6, 3'd6},
      '{3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
      '{3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd6, 3'd6, 3'd6, 3'd0},
      '{3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd7, 3'd7, 3'd7},
      '{3'd0, 3'd0, 3'd3, 3'd0, 3'd0, 3'd0, 3'd3, 3'd3}
   };

endpackage

// ===== design/traffic_light_phase_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_core: two-road traffic phase controller
// Table-driven Moore controller with a pedestrian crossing; one request per
// tick, one response per request with the lights of the new phase.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/ready     car_road1, car_road2, pedestrian
//   rsp_      out        rsp_valid/ready     road1/road2/walk lights, phase,
//                                            phase_changed
//   csr_      in         csr_write_en        csr_index, csr_wdata (16 bits)
//
// A request is captured in the input register, stepped through the counter
// compare and table lookup, and its response lands in the output register
// when the step fires, and rsp_valid rises in the cycle after it fires; one
// request per cycle is sustained while rsp_ready stays high.
// The output register decouples the sides; req_ready drops only while both
// registers are full and rsp_ready is low.
// Synchronous reset clears both valid bits, the phase (road 1 green), the
// tick count and loads the dwell reset values.
// ----------------------------------------------------------------------------
module traffic_light_phase_controller_core (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_car_road1,
   input  logic                    req_car_road2,
   input  logic                    req_pedestrian,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tlpc_pkg::road_light_type rsp_road1_light,
   output tlpc_pkg::road_light_type rsp_road2_light,
   output logic                    rsp_walk_light,
   output tlpc_pkg::phase_type     rsp_phase,
   output logic                    rsp_phase_changed,
   // dwell registers
   input  logic                    csr_write_en,
   input  tlpc_pkg::csr_index_type csr_index,
   input  tlpc_pkg::csr_data_type  csr_wdata
);
   import tlpc_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   req_bits_type    req_bits_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   step_result_type out_ff;
   step_result_type step_result;
   dwell_set_type   dwell;
   logic            req_take;
   logic            step_fire;

   // advance the held request when the output register is free or draining
   assign step_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers: hold until the next transfer
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_bits_ff <= {req_pedestrian, req_car_road2, req_car_road1};
      end
      if (step_fire) begin
         out_ff <= step_result;
      end
   end

   tlpc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .dwell        (dwell)
   );

   tlpc_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (step_fire),
      .req_bits (req_bits_ff),
      .dwell    (dwell),
      .result   (step_result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_road1_light   = out_ff.road1_light;
   assign rsp_road2_light   = out_ff.road2_light;
   assign rsp_walk_light    = out_ff.walk_light;
   assign rsp_phase         = out_ff.phase;
   assign rsp_phase_changed = out_ff.phase_changed;

endmodule

// ===== design/tlpc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_csr: dwell register file
// Five 16-bit dwell registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tlpc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  tlpc_pkg::csr_index_type csr_index,
   input  tlpc_pkg::csr_data_type  csr_wdata,
   output tlpc_pkg::dwell_set_type dwell
);
   import tlpc_pkg::*;

   dwell_set_type dwell_ff;
   dwell_set_type dwell_in;

   always_comb begin
      dwell_in = dwell_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GREEN:      dwell_in.green      = csr_wdata;
            CSR_YELLOW:     dwell_in.yellow     = csr_wdata;
            CSR_ALL_RED:    dwell_in.all_red    = csr_wdata;
            CSR_WALK:       dwell_in.walk       = csr_wdata;
            CSR_WALK_CLEAR: dwell_in.walk_clear = csr_wdata;
            default:        dwell_in            = dwell_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff.green      <= RST_GREEN;
         dwell_ff.yellow     <= RST_YELLOW;
         dwell_ff.all_red    <= RST_ALL_RED;
         dwell_ff.walk       <= RST_WALK;
         dwell_ff.walk_clear <= RST_WALK_CLEAR;
      end else begin
         dwell_ff <= dwell_in;
      end
   end

   assign dwell = dwell_ff;

endmodule

// ===== design/tlpc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpc_step: phase and dwell counter
// Holds the current phase and tick count, computes the step result for the
// registered request and commits the new state when the step fires.
// ----------------------------------------------------------------------------
module tlpc_step (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  tlpc_pkg::req_bits_type    req_bits,
   input  tlpc_pkg::dwell_set_type   dwell,
   output tlpc_pkg::step_result_type result
);
   import tlpc_pkg::*;

   phase_type         phase_ff;
   phase_type         phase_in;
   count_type         count_ff;
   count_type         count_in;
   count_type         dwell_cur;
   logic [COUNT_W:0]  count_inc;
   logic              expire;

   // pick the dwell register serving the current phase
   always_comb begin
      unique case (phase_ff)
         PH_GREEN1, PH_GREEN2:     dwell_cur = dwell.green;
         PH_YELLOW1, PH_YELLOW2:   dwell_cur = dwell.yellow;
         PH_ALL_RED1, PH_ALL_RED2: dwell_cur = dwell.all_red;
         PH_WALK:                  dwell_cur = dwell.walk;
         PH_WALK_CLR:              dwell_cur = dwell.walk_clear;
         default:                  dwell_cur = dwell.green;
      endcase
   end

   // a zero dwell acts as one since the incremented count is at least one
   assign count_inc = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign expire    = count_inc >= {1'b0, dwell_cur};

   always_comb begin
      if (expire) begin
         phase_in = NEXT_TAB[phase_ff][req_bits];
         count_in = '0;
      end else begin
         phase_in = phase_ff;
         count_in = count_inc[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GREEN1;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // lights of the phase in force after the step
   always_comb begin
      result.phase         = phase_in;
      result.phase_changed = expire;
      result.road1_light   = LIGHT_RED;
      result.road2_light   = LIGHT_RED;
      result.walk_light    = 1'b0;
      unique case (phase_in)
         PH_GREEN1:  result.road1_light = LIGHT_GREEN;
         PH_YELLOW1: result.road1_light = LIGHT_YELLOW;
         PH_GREEN2:  result.road2_light = LIGHT_GREEN;
         PH_YELLOW2: result.road2_light = LIGHT_YELLOW;
         PH_WALK:    result.walk_light  = 1'b1;
         default:    result.walk_light  = 1'b0;
      endcase
   end

endmodule

// ===== tb/tb_traffic_light_phase_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_traffic_light_phase_controller_core: self-checking bench of the phase core
// Drives tick requests with random request bits and random gaps, stalls the
// response side at random, and checks every response against an in-bench
// phase predictor that tracks phase, tick count and the dwell registers.
// ----------------------------------------------------------------------------
module tb_traffic_light_phase_controller_core;
   import tlpc_pkg::*;

   // indexes past the last dwell register; writes there must change nothing
   localparam csr_index_type CSR_SPARE5 = 3'd5;
   localparam csr_index_type CSR_SPARE6 = 3'd6;
   localparam csr_index_type CSR_SPARE7 = 3'd7;

   localparam int IDLE_PCT     = 16;
   localparam int RAND_CHUNKS  = 10;
   localparam int CHUNK_ITEMS  = 60;
   localparam int LONG_ITEMS   = 120;
   localparam count_type DWELL_MAX = 16'hFFFF;

   // short aliases so the next-phase table stays readable
   localparam phase_type G1 = PH_GREEN1,  Y1 = PH_YELLOW1, R1 = PH_ALL_RED1;
   localparam phase_type G2 = PH_GREEN2,  Y2 = PH_YELLOW2, R2 = PH_ALL_RED2;
   localparam phase_type WK = PH_WALK,    WC = PH_WALK_CLR;

   // next phase: row = phase in force, column = car_road1 | car_road2<<1 | ped<<2
   localparam phase_type PHASE_NEXT [NUM_PHASE][NUM_PHASE] = '{
      '{G1, G1, Y1, Y1, Y1, Y1, Y1, Y1},
      '{R1, R1, R1, R1, R1, R1, R1, R1},
      '{G2, G2, G2, G2, WK, WK, WK, WK},
      '{G2, Y2, G2, Y2, Y2, Y2, Y2, Y2},
      '{R2, R2, R2, R2, R2, R2, R2, R2},
      '{G1, G1, G1, G1, WK, WK, WK, G1},
      '{WC, WC, WC, WC, WK, WC, WC, WC},
      '{G1, G1, G2, G1, G1, G1, G2, G2}
   };

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      csr_index_type   idx;
      csr_data_type    data;
      req_bits_type    req;
      logic            typed;
      step_result_type want;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_car_road1;
   logic                req_car_road2;
   logic                req_pedestrian;
   logic                rsp_valid;
   logic                rsp_ready;
   road_light_type      rsp_road1_light;
   road_light_type      rsp_road2_light;
   logic                rsp_walk_light;
   phase_type           rsp_phase;
   logic                rsp_phase_changed;
   logic                csr_write_en;
   csr_index_type       csr_index;
   csr_data_type        csr_wdata;

   // predictor state: phase, ticks spent in it, dwell registers
   phase_type           model_phase;
   count_type           model_count;
   count_type           model_dwell [5];

   step_result_type     pending_lights [$];
   dir_row_type         dir_rows [$];

   int                  idle_pct;
   int                  errors;
   int                  requests;
   int                  responses;
   int                  changes;
   int                  dwell_writes;

   traffic_light_phase_controller_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_car_road1     (req_car_road1),
      .req_car_road2     (req_car_road2),
      .req_pedestrian    (req_pedestrian),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_road1_light   (rsp_road1_light),
      .rsp_road2_light   (rsp_road2_light),
      .rsp_walk_light    (rsp_walk_light),
      .rsp_phase         (rsp_phase),
      .rsp_phase_changed (rsp_phase_changed),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // pick the dwell register that times a phase
   function automatic csr_index_type dwell_reg_of(phase_type ph);
      case (ph)
         PH_GREEN1, PH_GREEN2:     return CSR_GREEN;
         PH_YELLOW1, PH_YELLOW2:   return CSR_YELLOW;
         PH_ALL_RED1, PH_ALL_RED2: return CSR_ALL_RED;
         PH_WALK:                  return CSR_WALK;
         default:                  return CSR_WALK_CLEAR;
      endcase
   endfunction

   // advance the phase by one tick and return the lights of the new phase;
   // a dwell of zero behaves like one because the count is bumped first
   function automatic step_result_type advance_phase(req_bits_type r);
      step_result_type   res;
      logic [COUNT_W:0]  next_count;
      phase_type         ph;
      ph = model_phase;
      next_count = {1'b0, model_count} + 1'b1;
      res.phase_changed = 1'b0;
      if (next_count >= {1'b0, model_dwell[dwell_reg_of(ph)]}) begin
         ph = PHASE_NEXT[ph][r];
         next_count = '0;
         res.phase_changed = 1'b1;
      end
      model_phase = ph;
      model_count = next_count[COUNT_W-1:0];
      res.phase       = ph;
      res.road1_light = LIGHT_RED;
      res.road2_light = LIGHT_RED;
      res.walk_light  = 1'b0;
      case (ph)
         PH_GREEN1:  res.road1_light = LIGHT_GREEN;
         PH_YELLOW1: res.road1_light = LIGHT_YELLOW;
         PH_GREEN2:  res.road2_light = LIGHT_GREEN;
         PH_YELLOW2: res.road2_light = LIGHT_YELLOW;
         PH_WALK:    res.walk_light  = 1'b1;
         default:    ;
      endcase
      return res;
   endfunction

   // mostly short dwells so phases turn over often, now and then zero or longer
   function automatic csr_data_type pick_dwell();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return '0;
      if (roll < 20) return 16'd1;
      if (roll < 85) return csr_data_type'($urandom_range(6, 2));
      return csr_data_type'($urandom_range(40, 7));
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------------

   function automatic dir_row_type tick_row(req_bits_type r);
      dir_row_type row;
      row = '0;
      row.kind = ROW_TICK;
      row.req  = r;
      return row;
   endfunction

   function automatic dir_row_type tick_want(req_bits_type r, road_light_type l1,
                                             road_light_type l2, logic wk,
                                             phase_type ph, logic chg);
      dir_row_type row;
      row = tick_row(r);
      row.typed = 1'b1;
      row.want  = '{road1_light: l1, road2_light: l2, walk_light: wk,
                    phase: ph, phase_changed: chg};
      return row;
   endfunction

   function automatic dir_row_type write_row(csr_index_type i, csr_data_type d);
      dir_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.idx  = i;
      row.data = d;
      return row;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver tasks
   // ---------------------------------------------------------------------------

   // drop valid and hold until every response in flight has come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_lights.size() != 0) @(negedge clock);
   endtask

   // write one dwell register; only ever called with the core drained
   task automatic write_dwell(csr_index_type i, csr_data_type d);
      wait_idle();
      csr_write_en = 1'b1;
      csr_index    = i;
      csr_wdata    = d;
      @(posedge clock);
      if (i <= CSR_WALK_CLEAR) model_dwell[i] = d;
      dwell_writes++;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // offer one tick request, maybe after a random gap, and hold it until taken;
   // a typed row replaces the predicted response with its own
   task automatic send_tick(req_bits_type r, logic typed, step_result_type want);
      step_result_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_car_road1  = r[0];
      req_car_road2  = r[1];
      req_pedestrian = r[2];
      do @(posedge clock); while (!req_ready);
      predicted = advance_phase(r);
      pending_lights.push_back(typed ? want : predicted);
      requests++;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random stalls, then compare against the oldest expectation
   // ---------------------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : response_check
      step_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses++;
         if (rsp_phase_changed) changes++;
         if (pending_lights.size() == 0) begin
            $display("%0t ns: response with no request waiting, phase %0d",
                     $time, rsp_phase);
            errors++;
         end else begin
            want = pending_lights.pop_front();
            check_field("road1_light",   want.road1_light,   rsp_road1_light);
            check_field("road2_light",   want.road2_light,   rsp_road2_light);
            check_field("walk_light",    want.walk_light,    rsp_walk_light);
            check_field("phase",         want.phase,         rsp_phase);
            check_field("phase_changed", want.phase_changed, rsp_phase_changed);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_car_road1  = 1'b0;
      req_car_road2  = 1'b0;
      req_pedestrian = 1'b0;
      csr_write_en   = 1'b0;
      csr_index      = CSR_GREEN;
      csr_wdata      = '0;
      idle_pct       = IDLE_PCT;
      errors         = 0;
      requests       = 0;
      responses      = 0;
      changes        = 0;
      dwell_writes   = 0;

      model_phase = PH_GREEN1;
      model_count = '0;
      model_dwell = '{RST_GREEN, RST_YELLOW, RST_ALL_RED, RST_WALK, RST_WALK_CLEAR};

      // Directed part. Out of reset the green dwell is long, so the first ticks
      // must hold road 1 green. Then zero every dwell so each tick transitions,
      // poke the unused indexes with all ones (a stray hit would freeze a
      // phase), and walk the table through every phase, including a
      // transition back into the same phase and a repeated walk. Last, lower
      // the dwells mid-phase below the running count: the next tick must move.
      dir_rows = '{
         tick_want(3'b000, LIGHT_GREEN, LIGHT_RED, 1'b0, PH_GREEN1, 1'b0),
         tick_want(3'b111, LIGHT_GREEN, LIGHT_RED, 1'b0, PH_GREEN1, 1'b0),
         write_row(CSR_GREEN,      16'h0000),
         write_row(CSR_YELLOW,     16'h0000),
         write_row(CSR_ALL_RED,    16'h0000),
         write_row(CSR_WALK,       16'h0000),
         write_row(CSR_WALK_CLEAR, 16'h0000),
         write_row(CSR_SPARE5,     16'hFFFF),
         write_row(CSR_SPARE6,     16'hFFFF),
         write_row(CSR_SPARE7,     16'hFFFF),
         tick_want(3'b001, LIGHT_GREEN, LIGHT_RED, 1'b0, PH_GREEN1, 1'b1),
         tick_row(3'b010),
         tick_row(3'b111),
         tick_want(3'b100, LIGHT_RED, LIGHT_RED, 1'b1, PH_WALK, 1'b1),
         tick_row(3'b100),
         tick_row(3'b000),
         tick_row(3'b010),
         tick_row(3'b000),
         tick_row(3'b001),
         tick_row(3'b101),
         tick_row(3'b100),
         tick_row(3'b011),
         tick_row(3'b110),
         tick_row(3'b111),
         tick_row(3'b000),
         tick_row(3'b111),
         write_row(CSR_GREEN,      16'd10),
         write_row(CSR_YELLOW,     16'd10),
         write_row(CSR_ALL_RED,    16'd10),
         write_row(CSR_WALK,       16'd10),
         write_row(CSR_WALK_CLEAR, 16'd10),
         tick_row(3'b000),
         tick_row(3'b001),
         tick_row(3'b010),
         tick_row(3'b100),
         write_row(CSR_GREEN,      16'd2),
         write_row(CSR_YELLOW,     16'd2),
         write_row(CSR_ALL_RED,    16'd2),
         write_row(CSR_WALK,       16'd2),
         write_row(CSR_WALK_CLEAR, 16'd2),
         tick_row(3'b011)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[n]) begin
         if (dir_rows[n].kind == ROW_WRITE)
            write_dwell(dir_rows[n].idx, dir_rows[n].data);
         else
            send_tick(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].want);
      end

      // Random part: each chunk drains the core, loads a fresh dwell set (the
      // first one all ones, the shortest nonzero dwell) plus a stray write to an
      // unused index, then runs ticks with random request bits. The phase and
      // count carry over, so new dwells often land below a running count.
      for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
         write_dwell(CSR_GREEN,      (chunk == 0) ? 16'd1 : pick_dwell());
         write_dwell(CSR_YELLOW,     (chunk == 0) ? 16'd1 : pick_dwell());
         write_dwell(CSR_ALL_RED,    (chunk == 0) ? 16'd1 : pick_dwell());
         write_dwell(CSR_WALK,       (chunk == 0) ? 16'd1 : pick_dwell());
         write_dwell(CSR_WALK_CLEAR, (chunk == 0) ? 16'd1 : pick_dwell());
         write_dwell(csr_index_type'($urandom_range(CSR_SPARE7, CSR_SPARE5)),
                     csr_data_type'($urandom()));
         for (int k = 0; k < CHUNK_ITEMS; k++)
            send_tick(req_bits_type'($urandom_range(7)), 1'b0, '0);
      end

      // Longest dwell: green at full scale, everything else at one tick, run
      // a stretch with no gaps or stalls; the phases race round to a green and
      // hold it there for the rest of the stretch.
      idle_pct = 0;
      write_dwell(CSR_GREEN,      DWELL_MAX);
      write_dwell(CSR_YELLOW,     16'd1);
      write_dwell(CSR_ALL_RED,    16'd1);
      write_dwell(CSR_WALK,       16'd1);
      write_dwell(CSR_WALK_CLEAR, 16'd1);
      for (int k = 0; k < LONG_ITEMS; k++)
         send_tick(req_bits_type'($urandom_range(7)), 1'b0, '0);

      // drain, then give the pipe a few more edges to show any stray response
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Sent %0d tick requests and %0d dwell writes; %0d responses, %0d phase changes.",
               requests, dwell_writes, responses, changes);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
